### sv/dpsm_pkg.sv
// ----------------------------------------------------------------------------
// dpsm_pkg
// Types and constants for the drive progress stuck monitor.
// ----------------------------------------------------------------------------
package dpsm_pkg;

  typedef enum logic [1:0] {
    MODE_DRIVE_SAMPLE = 2'd0,
    MODE_TURN_START   = 2'd1,
    MODE_TURN_SAMPLE  = 2'd2,
    MODE_CLEAR_ALL    = 2'd3
  } mode_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CFG_COMMAND_SPEED_MIN  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_ENCODER_SPEED_MIN  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_DRIVE_STUCK_TIME   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_MISMATCH_SPEED_MIN = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_MISMATCH_RATIO_Q8  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_MISMATCH_TIME      = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CFG_TURN_STUCK_TIME    = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CFG_TURN_YAW_MIN       = 3'd7;

  // Expected ratio of slow to fast target, Q1.8
  localparam logic [8:0] EXPECTED_RATIO_Q8 = 9'd192;

  // Heading wrap limits in centidegrees
  localparam logic signed [17:0] HalfTurn     = 18'sd18000;
  localparam logic signed [17:0] NegHalfTurn  = -18'sd18000;
  localparam logic signed [17:0] OneHalfTurn  = 18'sd54000;
  localparam logic signed [17:0] NegOneHalf   = -18'sd54000;
  localparam logic signed [17:0] FullTurn     = 18'sd36000;
  localparam logic signed [17:0] TwoTurns     = 18'sd72000;

  // Magnitude of a 16-bit signed speed; -32768 maps to 32768
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] neg;
    neg = 16'(-v);
    return v[15] ? neg : 16'(v);
  endfunction

endpackage

### sv/drive_progress_stuck_monitor_unit.sv
// ----------------------------------------------------------------------------
// drive_progress_stuck_monitor_unit
// Flags a stuck drive, mismatched wheels and a stalled turn from samples.
// ----------------------------------------------------------------------------
// The input register loads at the accepting edge; the flags and result then
// register from it once the output can advance.
// Throughput: one item per cycle when not stalled; the input register and the
// result register form a two-stage pipeline; tready follows output space.
// Reset clears all flags, armed bits and timestamps and loads the register
// defaults; the first item may be accepted in the cycle after reset.
module drive_progress_stuck_monitor_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_ms[31:0], left_target[47:32], right_target[63:48],
  // left_measured[79:64], right_measured[95:80], heading[111:96]
  input  logic [111:0]                       s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]                         s_axis_tuser,
  // master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // drive_stuck[0], mismatch_stuck[1], turn_stuck[2], zero fill[7:3]
  output logic [7:0]                         m_axis_tdata,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [dpsm_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [dpsm_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  // Configuration registers
  logic [14:0] cmd_speed_min_q, enc_speed_min_q, mm_speed_min_q, turn_yaw_min_q;
  logic [15:0] drive_time_q, mm_time_q, turn_time_q;
  logic [8:0]  mm_ratio_q;

  // Input register
  logic                  in_valid_q;
  dpsm_pkg::mode_e       in_mode_q;
  logic [31:0]           in_now_q;
  logic signed [15:0]    in_lt_q, in_rt_q, in_lm_q, in_rm_q, in_heading_q;

  // Monitor state
  logic               drive_armed_q, drive_armed_d, drive_flag_q, drive_flag_d;
  logic [31:0]        drive_since_q, drive_since_d;
  logic               mm_armed_q, mm_armed_d, mm_flag_q, mm_flag_d;
  logic [31:0]        mm_since_q, mm_since_d;
  logic               turn_flag_q, turn_flag_d;
  logic [31:0]        turn_since_q, turn_since_d;
  logic signed [15:0] turn_head_q, turn_head_d;
  logic               out_valid_q;

  logic in_accept, advance;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, turn_flag_q, mm_flag_q, drive_flag_q};

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_speed_min_q <= 15'd200;
      enc_speed_min_q <= 15'd50;
      drive_time_q    <= 16'd1000;
      mm_speed_min_q  <= 15'd200;
      mm_ratio_q      <= 9'd77;
      mm_time_q       <= 16'd1000;
      turn_time_q     <= 16'd1500;
      turn_yaw_min_q  <= 15'd500;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dpsm_pkg::CFG_COMMAND_SPEED_MIN:  cmd_speed_min_q <= cfg_data_i[14:0];
        dpsm_pkg::CFG_ENCODER_SPEED_MIN:  enc_speed_min_q <= cfg_data_i[14:0];
        dpsm_pkg::CFG_DRIVE_STUCK_TIME:   drive_time_q    <= cfg_data_i;
        dpsm_pkg::CFG_MISMATCH_SPEED_MIN: mm_speed_min_q  <= cfg_data_i[14:0];
        dpsm_pkg::CFG_MISMATCH_RATIO_Q8:  mm_ratio_q      <= cfg_data_i[8:0];
        dpsm_pkg::CFG_MISMATCH_TIME:      mm_time_q       <= cfg_data_i;
        dpsm_pkg::CFG_TURN_STUCK_TIME:    turn_time_q     <= cfg_data_i;
        dpsm_pkg::CFG_TURN_YAW_MIN:       turn_yaw_min_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_mode_q    <= dpsm_pkg::mode_e'(s_axis_tuser);
      in_now_q     <= s_axis_tdata[31:0];
      in_lt_q      <= s_axis_tdata[47:32];
      in_rt_q      <= s_axis_tdata[63:48];
      in_lm_q      <= s_axis_tdata[79:64];
      in_rm_q      <= s_axis_tdata[95:80];
      in_heading_q <= s_axis_tdata[111:96];
    end
  end

  // ------------------------------------------------------- evaluation logic
  logic [15:0]        lt_mag, rt_mag, lm_mag, rm_mag;
  logic [15:0]        max_t, min_t, max_m, min_m;
  logic [16:0]        t_sum, m_sum;
  logic               drive_cond, comparable, mm_cond;
  logic [24:0]        exp_prod, mm_prod;
  logic [31:0]        drive_ref, mm_ref, drive_age, mm_age, turn_age;
  logic signed [17:0] hd_diff, hd_wrap, hd_abs;

  always_comb begin
    lt_mag = dpsm_pkg::mag16(in_lt_q);
    rt_mag = dpsm_pkg::mag16(in_rt_q);
    lm_mag = dpsm_pkg::mag16(in_lm_q);
    rm_mag = dpsm_pkg::mag16(in_rm_q);
    max_t  = (lt_mag > rt_mag) ? lt_mag : rt_mag;
    min_t  = (lt_mag > rt_mag) ? rt_mag : lt_mag;
    max_m  = (lm_mag > rm_mag) ? lm_mag : rm_mag;
    min_m  = (lm_mag > rm_mag) ? rm_mag : lm_mag;

    // compare sums against doubled thresholds instead of averaging
    t_sum = {1'b0, lt_mag} + {1'b0, rt_mag};
    m_sum = {1'b0, lm_mag} + {1'b0, rm_mag};
    drive_cond = (t_sum > {1'b0, cmd_speed_min_q, 1'b0}) &&
                 (m_sum < {1'b0, enc_speed_min_q, 1'b0});

    exp_prod   = 25'(max_t) * 25'(dpsm_pkg::EXPECTED_RATIO_Q8);
    mm_prod    = 25'(max_m) * 25'(mm_ratio_q);
    comparable = (max_t > {1'b0, mm_speed_min_q}) &&
                 ({1'b0, min_t, 8'b0} >= exp_prod);
    mm_cond    = comparable && (max_m > {1'b0, mm_speed_min_q}) &&
                 ({1'b0, min_m, 8'b0} < mm_prod);

    // a fresh arm starts the timer at the current sample
    drive_ref = drive_armed_q ? drive_since_q : in_now_q;
    mm_ref    = mm_armed_q ? mm_since_q : in_now_q;
    drive_age = in_now_q - drive_ref;
    mm_age    = in_now_q - mm_ref;
    turn_age  = in_now_q - turn_since_q;

    // wrap heading change into (-180, 180] degrees
    hd_diff = 18'(in_heading_q) - 18'(turn_head_q);
    if (hd_diff > dpsm_pkg::OneHalfTurn) begin
      hd_wrap = hd_diff - dpsm_pkg::TwoTurns;
    end else if (hd_diff > dpsm_pkg::HalfTurn) begin
      hd_wrap = hd_diff - dpsm_pkg::FullTurn;
    end else if (hd_diff <= dpsm_pkg::NegOneHalf) begin
      hd_wrap = hd_diff + dpsm_pkg::TwoTurns;
    end else if (hd_diff <= dpsm_pkg::NegHalfTurn) begin
      hd_wrap = hd_diff + dpsm_pkg::FullTurn;
    end else begin
      hd_wrap = hd_diff;
    end
    hd_abs = hd_wrap[17] ? -hd_wrap : hd_wrap;
  end

  always_comb begin
    drive_armed_d = drive_armed_q;
    drive_flag_d  = drive_flag_q;
    drive_since_d = drive_since_q;
    mm_armed_d    = mm_armed_q;
    mm_flag_d     = mm_flag_q;
    mm_since_d    = mm_since_q;
    turn_flag_d   = turn_flag_q;
    turn_since_d  = turn_since_q;
    turn_head_d   = turn_head_q;

    case (in_mode_q)
      dpsm_pkg::MODE_DRIVE_SAMPLE: begin
        if (drive_cond) begin
          drive_armed_d = 1'b1;
          drive_since_d = drive_ref;
          if (drive_age > {16'b0, drive_time_q}) drive_flag_d = 1'b1;
        end else begin
          drive_armed_d = 1'b0;
          drive_flag_d  = 1'b0;
        end
        if (mm_cond) begin
          mm_armed_d = 1'b1;
          mm_since_d = mm_ref;
          if (mm_age > {16'b0, mm_time_q}) mm_flag_d = 1'b1;
        end else begin
          mm_armed_d = 1'b0;
          mm_flag_d  = 1'b0;
        end
      end
      dpsm_pkg::MODE_TURN_START: begin
        turn_since_d = in_now_q;
        turn_head_d  = in_heading_q;
        turn_flag_d  = 1'b0;
      end
      dpsm_pkg::MODE_TURN_SAMPLE: begin
        if (turn_age >= {16'b0, turn_time_q}) begin
          if (hd_abs[14:0] < turn_yaw_min_q) begin
            turn_flag_d = 1'b1;
          end else begin
            // progress made: re-arm from here
            turn_flag_d  = 1'b0;
            turn_since_d = in_now_q;
            turn_head_d  = in_heading_q;
          end
        end
      end
      dpsm_pkg::MODE_CLEAR_ALL: begin
        drive_armed_d = 1'b0;
        drive_flag_d  = 1'b0;
        mm_armed_d    = 1'b0;
        mm_flag_d     = 1'b0;
        turn_flag_d   = 1'b0;
        turn_since_d  = in_now_q;
        turn_head_d   = in_heading_q;
      end
      default: ;
    endcase
  end

  // ----------------------------------------------- state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      drive_armed_q <= 1'b0;
      drive_flag_q  <= 1'b0;
      drive_since_q <= '0;
      mm_armed_q    <= 1'b0;
      mm_flag_q     <= 1'b0;
      mm_since_q    <= '0;
      turn_flag_q   <= 1'b0;
      turn_since_q  <= '0;
      turn_head_q   <= '0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      // commit state only with a transaction, so the flags hold as the result
      if (in_valid_q) begin
        drive_armed_q <= drive_armed_d;
        drive_flag_q  <= drive_flag_d;
        drive_since_q <= drive_since_d;
        mm_armed_q    <= mm_armed_d;
        mm_flag_q     <= mm_flag_d;
        mm_since_q    <= mm_since_d;
        turn_flag_q   <= turn_flag_d;
        turn_since_q  <= turn_since_d;
        turn_head_q   <= turn_head_d;
      end
    end
  end

  // ------------------------------------------------------------ assertions
  a_drive_flag_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_flag_q |-> drive_armed_q)
    else $error("drive flag set while drive timer disarmed");

  a_mm_flag_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_flag_q |-> mm_armed_q)
    else $error("mismatch flag set while mismatch timer disarmed");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && in_mode_q == dpsm_pkg::MODE_CLEAR_ALL) |=>
      (!drive_flag_q && !mm_flag_q && !turn_flag_q && !drive_armed_q && !mm_armed_q))
    else $error("clear-all left a flag or armed bit set");

  a_turn_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && in_mode_q == dpsm_pkg::MODE_TURN_START) |=>
      (!turn_flag_q && turn_since_q == $past(in_now_q)))
    else $error("turn start did not re-arm the turn check");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(drive_flag_q) && $stable(mm_flag_q) && $stable(turn_flag_q)))
    else $error("flags changed while the result was stalled");

endmodule
